// ===== sv/tpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Tag period estimator package
// Shared widths, table entry layout, fixed-point constants, register indexes,
// sequencer states and the tag-to-table index function.
// ----------------------------------------------------------------------------
package tpe_pkg;

   // Table geometry.
   localparam int TAG_TABLE_DEPTH = 1024;
   localparam int TAG_IDX_W       = $clog2(TAG_TABLE_DEPTH);

   // Field widths.
   localparam int TAG_ID_W   = 10;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 24;
   localparam int CONF_W     = 17;
   localparam int TOL_W      = 16;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = INTERVAL_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEFAULT_INTERVAL = 1'b0,
      CSR_TOLERANCE        = 1'b1
   } tpe_csr_type;

   localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL_RST = 24'd15000;
   localparam logic [TOL_W-1:0]      TOLERANCE_RST        = 16'd3277;

   // Q0.16 and Q1.16 constants.
   localparam logic [CONF_W-1:0] Q_ONE      = 17'h10000; // 1.0
   localparam logic [15:0]       K_DECAY    = 16'd62259; // 0.95
   localparam logic [15:0]       K_RISE_MUL = 16'd42598; // 0.65
   localparam logic [CONF_W-1:0] K_RISE_ADD = 17'd22938; // 0.35
   localparam logic [CONF_W-1:0] K_CLAMP    = 17'd64880; // 0.99
   localparam logic [15:0]       K_STEP     = 16'd58982; // 0.9

   // One table entry: all per-tag state lives in a single memory word.
   typedef struct packed {
      logic [TIME_W-1:0]     last_arrival;
      logic [INTERVAL_W-1:0] period_estimate;
      logic [CONF_W-1:0]     period_confidence;
   } tpe_entry_type;

   localparam int ENTRY_W = $bits(tpe_entry_type);

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_TOL,
      ST_CONF,
      ST_STEP,
      ST_MUL,
      ST_DONE
   } tpe_state_type;

   // Reduce a tag id modulo the table depth by a short restoring division
   // against elaboration-time multiples of the depth.
   function automatic logic [TAG_IDX_W-1:0] tag_index(input logic [TAG_ID_W-1:0] tag);
      logic [TAG_ID_W-1:0] rem;
      rem = tag;
      for (int j = TAG_ID_W - 1; j >= 0; j--) begin
         if ((longint'(TAG_TABLE_DEPTH) << j) <= longint'(rem)) begin
            rem = rem - TAG_ID_W'(longint'(TAG_TABLE_DEPTH) << j);
         end
      end
      return TAG_IDX_W'(rem);
   endfunction

endpackage

// ===== sv/tag_period_estimator_core.sv =====
// Sequence: a tracked tag passes READ, TOL, CONF, STEP and MUL, then DONE writes
// back and loads the result register; a first sighting goes from READ to DONE.
// Items are handled one at a time: a new one is taken only in IDLE, and DONE
// waits for the result register to be free, so back-pressure holds the input.
// Reset: synchronous; a clearing pass writes zero to all TAG_TABLE_DEPTH (1024)
// entries with req_tready low; configuration registers return to defaults.
// ----------------------------------------------------------------------------
// Tag period estimator core
// Per-tag beacon interval and confidence tracker built around one table RAM
// with a read-modify-write sequencer and a registered result stage.
// ----------------------------------------------------------------------------
module tag_period_estimator_core
   import tpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream: tag_id [9:0], time_ms [41:10], zero pad [47:42].
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Result stream: interval_ms [23:0], confidence_q16 [40:24], zero pad [47:41].
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Result user bit: first_seen [0].
   output logic                  rsp_tuser,
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Control state.
   tpe_state_type          state_ff, state_in;
   logic [TAG_IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INTERVAL_W-1:0]  default_ff, default_in;
   logic [TOL_W-1:0]       tol_ff, tol_in;

   // Item payload through the sequencer.
   logic [TAG_IDX_W-1:0]   idx_ff, idx_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [INTERVAL_W-1:0]  ival_ff, ival_in;
   logic [CONF_W-1:0]      conf_ff, conf_in;
   logic [INTERVAL_W-1:0]  dev_ff, dev_in;
   logic                   neg_ff, neg_in;
   logic                   first_ff, first_in;
   logic [39:0]            lim_ff, lim_in;
   logic [CONF_W-1:0]      decay_ff, decay_in;
   logic [CONF_W-1:0]      rise_ff, rise_in;
   logic [CONF_W-1:0]      conf_new_ff, conf_new_in;
   logic [CONF_W-1:0]      k_ff, k_in;
   logic [INTERVAL_W-1:0]  mag_ff, mag_in;

   // Result register payload.
   logic [INTERVAL_W-1:0]  rsp_ival_ff, rsp_ival_in;
   logic [CONF_W-1:0]      rsp_conf_ff, rsp_conf_in;
   logic                   rsp_first_ff, rsp_first_in;

   // Memory interface.
   logic                   ram_we, ram_re;
   logic [TAG_IDX_W-1:0]   ram_waddr;
   tpe_entry_type          ram_wdata, ram_rdata;

   // Intermediate datapath values.
   logic                   req_accept, out_free, done_go;
   logic [TIME_W-1:0]      gap_full;
   logic [INTERVAL_W-1:0]  gap_sat;
   logic                   rd_first;
   logic [32:0]            decay_prod, rise_prod, step_prod;
   logic [CONF_W-1:0]      rise_sum;
   logic                   out_band;
   logic [40:0]            mag_prod;
   logic [INTERVAL_W-1:0]  ival_new;

   // Table memory.
   tpe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TAG_TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (tag_index(req_tdata[TAG_ID_W-1:0])),
      .rdata (ram_rdata)
   );

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign done_go    = (state_ff == ST_DONE) && out_free;

   // Sequencer next state.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == TAG_IDX_W'(TAG_TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = rd_first ? ST_DONE : ST_TOL;
         ST_TOL:  state_in = ST_CONF;
         ST_CONF: state_in = ST_STEP;
         ST_STEP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff;
      ram_wdata  = '{last_arrival: time_ff, period_estimate: ival_new,
                     period_confidence: conf_new_ff};
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         ST_IDLE: req_tready = 1'b1;
         ST_DONE: ram_we = out_free;
         default: ;
      endcase
   end

   assign ram_re = req_accept;

   // Read stage: gap since last arrival, saturated to 24 bits.
   assign gap_full = time_ff - ram_rdata.last_arrival;
   assign gap_sat  = (|gap_full[TIME_W-1:INTERVAL_W]) ? '1 : gap_full[INTERVAL_W-1:0];
   assign rd_first = (ram_rdata.period_estimate == '0);

   // Multiplies of the confidence update and the step factor.
   assign decay_prod = conf_ff * K_DECAY;
   assign rise_prod  = conf_ff * K_RISE_MUL;
   assign rise_sum   = rise_ff + K_RISE_ADD;
   assign out_band   = {dev_ff, 16'h0000} > lim_ff;
   assign step_prod  = conf_new_ff * K_STEP;
   assign mag_prod   = dev_ff * k_ff;

   // Interval moves toward the gap by the scaled difference.
   assign ival_new = first_ff ? ival_ff : (neg_ff ? ival_ff - mag_ff : ival_ff + mag_ff);

   // Datapath next values.
   always_comb begin
      idx_in       = idx_ff;
      time_in      = time_ff;
      ival_in      = ival_ff;
      conf_in      = conf_ff;
      dev_in       = dev_ff;
      neg_in       = neg_ff;
      first_in     = first_ff;
      lim_in       = lim_ff;
      decay_in     = decay_ff;
      rise_in      = rise_ff;
      conf_new_in  = conf_new_ff;
      k_in         = k_ff;
      mag_in       = mag_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in  = tag_index(req_tdata[TAG_ID_W-1:0]);
            time_in = req_tdata[TAG_ID_W +: TIME_W];
         end
         ST_READ: begin
            first_in = rd_first;
            neg_in   = gap_sat < ram_rdata.period_estimate;
            dev_in   = (gap_sat < ram_rdata.period_estimate)
                       ? ram_rdata.period_estimate - gap_sat
                       : gap_sat - ram_rdata.period_estimate;
            if (rd_first) begin
               ival_in     = default_ff;
               conf_in     = '0;
               conf_new_in = '0;
            end else begin
               ival_in = ram_rdata.period_estimate;
               conf_in = ram_rdata.period_confidence;
            end
         end
         ST_TOL: begin
            lim_in   = tol_ff * ival_ff;
            decay_in = decay_prod[32:16];
            rise_in  = rise_prod[32:16];
         end
         ST_CONF: begin
            if (out_band) begin
               conf_new_in = decay_ff;
            end else if (rise_sum > K_CLAMP) begin
               conf_new_in = Q_ONE;
            end else begin
               conf_new_in = rise_sum;
            end
         end
         ST_STEP: k_in = Q_ONE - step_prod[32:16];
         ST_MUL:  mag_in = mag_prod[39:16];
         default: ;
      endcase
   end

   // Result register and configuration registers.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ival_in  = rsp_ival_ff;
      rsp_conf_in  = rsp_conf_ff;
      rsp_first_in = rsp_first_ff;
      if (done_go) begin
         rsp_valid_in = 1'b1;
         rsp_ival_in  = ival_new;
         rsp_conf_in  = conf_new_ff;
         rsp_first_in = first_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      default_in = default_ff;
      tol_in     = tol_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DEFAULT_INTERVAL: default_in = csr_wdata;
            CSR_TOLERANCE:        tol_in     = csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         default_ff   <= DEFAULT_INTERVAL_RST;
         tol_ff       <= TOLERANCE_RST;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         default_ff   <= default_in;
         tol_ff       <= tol_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      time_ff      <= time_in;
      ival_ff      <= ival_in;
      conf_ff      <= conf_in;
      dev_ff       <= dev_in;
      neg_ff       <= neg_in;
      first_ff     <= first_in;
      lim_ff       <= lim_in;
      decay_ff     <= decay_in;
      rise_ff      <= rise_in;
      conf_new_ff  <= conf_new_in;
      k_ff         <= k_in;
      mag_ff       <= mag_in;
      rsp_ival_ff  <= rsp_ival_in;
      rsp_conf_ff  <= rsp_conf_in;
      rsp_first_ff <= rsp_first_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - INTERVAL_W - CONF_W)'(0), rsp_conf_ff, rsp_ival_ff};
   assign rsp_tuser  = rsp_first_ff;

`ifndef SYNTHESIS
   // No input transaction while the table is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("input accepted during table clear");

   // The table is written only by the clearing pass or at write-back.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_DONE))
      else $error("unexpected table write");

   // An accepted item is read from the table in the following cycle.
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_READ))
      else $error("accepted item not followed by table read");

   // A new result comes only from the write-back step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result appeared outside write-back");

   // Confidence never exceeds one.
   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_conf_ff <= Q_ONE))
      else $error("confidence above one");
`endif

endmodule

// ===== sv/tpe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== dv/tag_period_estimator_core_test.sv =====
// ----------------------------------------------------------------------------
// Tag period estimator core testbench
// Drives beacon sightings into the core, predicts every interval and
// confidence update with a local copy of the tag table, and compares each
// result transaction against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tag_period_estimator_core_test;
   import tpe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 5000;
   localparam int REPORT_LIMIT  = 10;
   localparam int BEACON_POOL   = 12;

   // Q1.16 factors of the confidence and step update.
   localparam longint unsigned ONE_Q16      = 65536;
   localparam longint unsigned DECAY_Q16    = 62259;
   localparam longint unsigned RISE_MUL_Q16 = 42598;
   localparam longint unsigned RISE_ADD_Q16 = 22938;
   localparam longint unsigned CLAMP_Q16    = 64880;
   localparam longint unsigned STEP_Q16     = 58982;
   localparam longint unsigned MAX_INTERVAL = 24'hFFFFFF;

   typedef struct packed {
      logic [INTERVAL_W-1:0] interval_ms;
      logic [CONF_W-1:0]     confidence_q16;
      logic                  first_seen;
   } estimate_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // Fields: tag_id [9:0], time_ms [41:10], zero pad [47:42].
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // Fields: interval_ms [23:0], confidence_q16 [40:24], zero pad [47:41].
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // Fields: first_seen [0].
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_DEFAULT_INTERVAL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the configuration registers and of the tag table.
   logic [INTERVAL_W-1:0] cfg_default_interval = DEFAULT_INTERVAL_RST;
   logic [TOL_W-1:0]      cfg_tolerance        = TOLERANCE_RST;
   bit [TIME_W-1:0]       arrival_tab    [TAG_TABLE_DEPTH];
   bit [INTERVAL_W-1:0]   interval_tab   [TAG_TABLE_DEPTH];
   bit [CONF_W-1:0]       confidence_tab [TAG_TABLE_DEPTH];

   estimate_type pending_estimates [$];
   int        mismatch_count = 0;
   int        idle_cycles    = 0;
   int        req_idle_pct   = 0;
   int        rsp_stall_pct  = 0;

   tag_period_estimator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4ns clock = 1'b1;
      #4ns clock = 1'b0;
   end

   function automatic longint unsigned q16_scale(input longint unsigned value,
                                                 input longint unsigned factor);
      return (value * factor) >> 16;
   endfunction

   // Apply one sighting to the shadow table and return the expected update.
   function automatic estimate_type update_tag_estimate(input logic [TAG_ID_W-1:0] tag,
                                                        input logic [TIME_W-1:0]   now);
      int unsigned       slot;
      logic [TIME_W-1:0] wrapped_gap;
      longint unsigned   ival, conf, gap, dev, lim, step_k, delta;
      estimate_type      est;
      slot = tag % TAG_TABLE_DEPTH;
      ival = interval_tab[slot];
      conf = confidence_tab[slot];
      est.first_seen = 1'b0;
      if (ival == 0) begin
         ival = cfg_default_interval;
         conf = 0;
         est.first_seen = 1'b1;
      end else begin
         wrapped_gap = now - arrival_tab[slot];
         gap = wrapped_gap;
         if (gap > MAX_INTERVAL) begin
            gap = MAX_INTERVAL;
         end
         dev = (gap > ival) ? gap - ival : ival - gap;
         lim = cfg_tolerance * ival;
         // Outside the tolerance band the confidence decays, inside it rises.
         if ((dev << 16) > lim) begin
            conf = q16_scale(conf, DECAY_Q16);
         end else begin
            conf = q16_scale(conf, RISE_MUL_Q16) + RISE_ADD_Q16;
            if (conf > CLAMP_Q16) begin
               conf = ONE_Q16;
            end
         end
         conf = conf & 64'h1FFFF;
         // Move toward the gap by a step that shrinks as confidence grows.
         step_k = ONE_Q16 - q16_scale(conf, STEP_Q16);
         delta = (dev * step_k) >> 16;
         ival = (gap >= ival) ? ival + delta : ival - delta;
         ival = ival & MAX_INTERVAL;
      end
      arrival_tab[slot]    = now;
      interval_tab[slot]   = INTERVAL_W'(ival);
      confidence_tab[slot] = CONF_W'(conf);
      est.interval_ms      = INTERVAL_W'(ival);
      est.confidence_q16   = CONF_W'(conf);
      return est;
   endfunction

   // Send one sighting; valid stays high afterwards unless the next one idles.
   task automatic send_beacon(input logic [TAG_ID_W-1:0] tag, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({now, tag});
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      pending_estimates.push_back(update_tag_estimate(tag, now));
   endtask

   // Stop sending and wait until every predicted result has been checked.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input tpe_csr_type which, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= value;
      @(posedge clock);
      case (which)
         CSR_DEFAULT_INTERVAL: cfg_default_interval = value;
         CSR_TOLERANCE:        cfg_tolerance = value[TOL_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Reset defaults: first sightings, exact and off-band gaps, time wrap,
   // gap saturation and an interval that collapses to zero.
   task automatic test_directed_defaults();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_beacon(10'd0, 32'd0);
      send_beacon(10'd0, 32'd15000);
      send_beacon(10'd0, 32'd30400);
      send_beacon(10'd0, 32'd70400);
      send_beacon(10'd1023, 32'hFFFF_FFFF);
      send_beacon(10'd1023, 32'd14999);
      send_beacon(10'h155, 32'd0);
      send_beacon(10'h155, 32'hFFFF_FFFF);
      // A zero gap at zero confidence takes the whole step and empties the
      // interval, so the following sighting starts over.
      send_beacon(10'h2AA, 32'd100);
      send_beacon(10'h2AA, 32'd100);
      send_beacon(10'h2AA, 32'd200);
      drain_results();
   endtask

   // Register extremes, including a zero default that re-initializes forever.
   task automatic test_register_extremes();
      write_register(CSR_DEFAULT_INTERVAL, 24'hFFFFFF);
      write_register(CSR_TOLERANCE, 24'hFFFF);
      send_beacon(10'd3, 32'd1000);
      send_beacon(10'd3, 32'h0200_03E8);
      send_beacon(10'd3, 32'h0200_03ED);
      drain_results();
      write_register(CSR_DEFAULT_INTERVAL, 24'd0);
      send_beacon(10'd9, 32'd50);
      send_beacon(10'd9, 32'd80);
      drain_results();
      write_register(CSR_DEFAULT_INTERVAL, 24'd1);
      write_register(CSR_TOLERANCE, 24'd0);
      send_beacon(10'd11, 32'd7);
      send_beacon(10'd11, 32'd8);
      send_beacon(10'd11, 32'd10);
      drain_results();
   endtask

   // Mostly periodic beacons from a pool of tags with jitter and missed
   // beacons, mixed with random sightings of arbitrary tags.
   task automatic test_random_beacons(input int n_items, input int idle_pct,
                                      input int stall_pct,
                                      input logic [INTERVAL_W-1:0] dflt,
                                      input logic [TOL_W-1:0] tol);
      logic [TAG_ID_W-1:0] pool_tag    [BEACON_POOL];
      logic [TIME_W-1:0]   pool_next   [BEACON_POOL];
      int unsigned         pool_period [BEACON_POOL];
      int unsigned         slot, pick, jitter_span;
      logic [TIME_W-1:0]   stamp;
      write_register(CSR_DEFAULT_INTERVAL, dflt);
      write_register(CSR_TOLERANCE, CSR_DATA_W'(tol));
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < BEACON_POOL; i++) begin
         pool_tag[i]  = TAG_ID_W'($urandom_range(0, (1 << TAG_ID_W) - 1));
         pool_next[i] = $urandom();
         case ($urandom_range(0, 3))
            0:       pool_period[i] = $urandom_range(1, 64);
            1, 2:    pool_period[i] = $urandom_range(100, 20000);
            default: pool_period[i] = $urandom_range(1000000, 30000000);
         endcase
      end
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_beacon(TAG_ID_W'($urandom_range(0, (1 << TAG_ID_W) - 1)), $urandom());
         end else begin
            slot  = $urandom_range(0, BEACON_POOL - 1);
            stamp = pool_next[slot];
            send_beacon(pool_tag[slot], stamp);
            jitter_span = pool_period[slot] / 64;
            pick = $urandom_range(99);
            if (pick < 15) begin
               pool_next[slot] = stamp + pool_period[slot];
            end else if (pick < 85) begin
               pool_next[slot] = stamp + pool_period[slot] - jitter_span
                                 + $urandom_range(0, 2 * jitter_span);
            end else begin
               pool_next[slot] = stamp + pool_period[slot] * $urandom_range(2, 3);
            end
         end
      end
      drain_results();
   endtask

   // Random backpressure on the result channel.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      estimate_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_estimates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("[%0t] unexpected result: interval %0d conf %0d first %0b",
                        $realtime, rsp_tdata[INTERVAL_W-1:0],
                        rsp_tdata[INTERVAL_W +: CONF_W], rsp_tuser);
            end
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_tdata[INTERVAL_W-1:0] !== want.interval_ms
                || rsp_tdata[INTERVAL_W +: CONF_W] !== want.confidence_q16
                || rsp_tuser !== want.first_seen) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("[%0t] result mismatch: interval exp %0d got %0d,",
                           $realtime, want.interval_ms, rsp_tdata[INTERVAL_W-1:0],
                           " conf exp %0d got %0d,",
                           want.confidence_q16, rsp_tdata[INTERVAL_W +: CONF_W],
                           " first exp %0b got %0b", want.first_seen, rsp_tuser);
               end
            end
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) === 1'b1 || (rsp_tvalid && rsp_tready) === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_register_extremes();
      test_random_beacons(250, 0, 0, DEFAULT_INTERVAL_RST, TOLERANCE_RST);
      test_random_beacons(250, 88, 0, INTERVAL_W'($urandom_range(1, 100000)), 16'hFFFF);
      test_random_beacons(250, 0, 88, 24'hFFFFFF, 16'd0);
      test_random_beacons(250, 9, 9, INTERVAL_W'($urandom_range(1, 24'hFFFFFF)),
                          TOL_W'($urandom_range(0, 16'hFFFF)));
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tpe_pkg.sv
sv/tpe_ram.sv
sv/tag_period_estimator_core.sv
dv/tag_period_estimator_core_test.sv
